// File: rtl/tbphc_pkg.sv
package tbphc_pkg;

    // Result command codes
    typedef enum logic [1:0] {
        CMD_ONE_PRESS = 2'd0,
        CMD_ONE_HOLD  = 2'd1,
        CMD_TWO_PRESS = 2'd2,
        CMD_TWO_HOLD  = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic {
        REG_UPDATE_INTERVAL = 1'b0,
        REG_LONG_PRESS_MS   = 1'b1
    } cfg_reg_t;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned CFG_W   = 16;

    localparam logic [CFG_W-1:0] UPDATE_INTERVAL_RST = 16'd4;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST   = 16'd750;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

    // Event from one button evaluation
    typedef struct packed {
        logic valid;
        logic hold;   // 1 hold, 0 press
    } btn_event_t;

endpackage

// File: rtl/tbphc_button.sv
module tbphc_button (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              eval_en,
    input  logic                              level,
    input  logic [tbphc_pkg::TIMER_W-1:0]     elapsed_sat,
    input  logic [tbphc_pkg::CFG_W-1:0]       long_press_ms,
    output tbphc_pkg::btn_event_t             evt
);

    logic                          prev_reg,   prev_next;
    logic                          locked_reg, locked_next;
    logic [tbphc_pkg::TIMER_W-1:0] timer_reg,  timer_next;
    logic [tbphc_pkg::TIMER_W:0]   sum;

    assign sum = {1'b0, timer_reg} + {1'b0, elapsed_sat};

    always_comb begin
        prev_next   = prev_reg;
        locked_next = locked_reg;
        timer_next  = timer_reg;
        evt         = '0;
        if (eval_en) begin
            prev_next = level;
            if (!locked_reg && prev_reg && level) begin
                // saturating press timer
                timer_next = sum[tbphc_pkg::TIMER_W] ? '1 : sum[tbphc_pkg::TIMER_W-1:0];
                if (timer_next >= long_press_ms) begin
                    locked_next = 1'b1;
                    evt.valid   = 1'b1;
                    evt.hold    = 1'b1;
                end
            end else if (prev_reg && !level) begin
                evt.valid   = !locked_reg;
                evt.hold    = 1'b0;
                locked_next = 1'b0;
                timer_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b0;
            locked_reg <= 1'b0;
            timer_reg  <= '0;
        end else begin
            prev_reg   <= prev_next;
            locked_reg <= locked_next;
            timer_reg  <= timer_next;
        end
    end

endmodule

// File: rtl/two_button_press_hold_classifier.sv
// Two-button press/hold classifier.
// Each sample beat is held in the input register, and its command, if any, in the result register.
// Throughput: one sample beat per cycle; the input register advances whenever the
//   result register is empty or being drained, so the only limit is m_tready.
// Reset (aresetn low, synchronous): both channels empty, all button state and the
//   last update time cleared, update_interval = 4, long_press_ms = 750.
module two_button_press_hold_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [tbphc_pkg::CFG_W-1:0]       cfg_wdata,

    // Sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] now_ms, [32] button_one_level, [33] button_two_level, [39:34] zero
    input  logic [tbphc_pkg::S_TDATA_W-1:0]   s_tdata,

    // Command stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] command, [7:2] zero
    output logic [tbphc_pkg::M_TDATA_W-1:0]   m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tbphc_pkg::CFG_W-1:0] update_interval_reg;
    logic [tbphc_pkg::CFG_W-1:0] long_press_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            update_interval_reg <= tbphc_pkg::UPDATE_INTERVAL_RST;
            long_press_ms_reg   <= tbphc_pkg::LONG_PRESS_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (tbphc_pkg::cfg_reg_t'(cfg_addr))
                tbphc_pkg::REG_UPDATE_INTERVAL: update_interval_reg <= cfg_wdata;
                tbphc_pkg::REG_LONG_PRESS_MS:   long_press_ms_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: one sample beat
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic [tbphc_pkg::TIME_W-1:0]  in_now_reg;
    logic                          in_b1_reg;
    logic                          in_b2_reg;
    logic                          proc_fire;
    logic                          s_fire;

    // The sample in the input register is processed when the result slot is free
    // or drains in this same cycle.
    assign proc_fire = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_now_reg <= s_tdata[tbphc_pkg::TIME_W-1:0];
            in_b1_reg  <= s_tdata[tbphc_pkg::TIME_W];
            in_b2_reg  <= s_tdata[tbphc_pkg::TIME_W+1];
        end
    end

    // ------------------------------------------------------------------
    // Interval gate
    // ------------------------------------------------------------------
    logic [tbphc_pkg::TIME_W-1:0]  last_update_reg, last_update_next;
    logic [tbphc_pkg::TIME_W-1:0]  elapsed;
    logic [tbphc_pkg::TIMER_W-1:0] elapsed_sat;
    logic                          went_back;
    logic                          evaluate;

    // A timestamp behind the last update restarts the interval at now:
    // elapsed reads as zero in that case.
    assign went_back   = in_now_reg < last_update_reg;
    assign elapsed     = went_back ? '0 : (in_now_reg - last_update_reg);
    assign elapsed_sat = (|elapsed[tbphc_pkg::TIME_W-1:tbphc_pkg::TIMER_W])
                         ? '1 : elapsed[tbphc_pkg::TIMER_W-1:0];
    assign evaluate    = proc_fire &&
                         (elapsed >= {{(tbphc_pkg::TIME_W-tbphc_pkg::CFG_W){1'b0}},
                                      update_interval_reg});

    // The last update time also follows a backward step on ignored samples.
    assign last_update_next = (proc_fire && (went_back || evaluate))
                              ? in_now_reg : last_update_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_update_reg <= '0;
        end else begin
            last_update_reg <= last_update_next;
        end
    end

    // ------------------------------------------------------------------
    // Per-button logic
    // ------------------------------------------------------------------
    tbphc_pkg::btn_event_t evt_one, evt_two;

    tbphc_button u_btn_one (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eval_en       (evaluate),
        .level         (in_b1_reg),
        .elapsed_sat   (elapsed_sat),
        .long_press_ms (long_press_ms_reg),
        .evt           (evt_one)
    );

    tbphc_button u_btn_two (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eval_en       (evaluate),
        .level         (in_b2_reg),
        .elapsed_sat   (elapsed_sat),
        .long_press_ms (long_press_ms_reg),
        .evt           (evt_two)
    );

    // Button two wins when both report in the same sample.
    tbphc_pkg::cmd_t cmd;
    logic            have;

    always_comb begin
        have = evt_one.valid || evt_two.valid;
        priority if (evt_two.valid) begin
            cmd = evt_two.hold ? tbphc_pkg::CMD_TWO_HOLD : tbphc_pkg::CMD_TWO_PRESS;
        end else if (evt_one.valid) begin
            cmd = evt_one.hold ? tbphc_pkg::CMD_ONE_HOLD : tbphc_pkg::CMD_ONE_PRESS;
        end else begin
            cmd = tbphc_pkg::CMD_ONE_PRESS;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic            out_valid_reg;
    tbphc_pkg::cmd_t out_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= have;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && have) begin
            out_cmd_reg <= cmd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tbphc_pkg::M_TDATA_W-2){1'b0}}, out_cmd_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_event_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && have) |=> (m_tvalid && m_tdata[1:0] == $past(cmd)))
        else $error("event not presented on result channel");

    a_quiet_sample_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && !have) |=> !m_tvalid)
        else $error("beat presented for a sample without event");

    a_stalled_sample_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_now_reg)))
        else $error("stalled sample lost or changed");

    a_ignored_sample_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && !evaluate) |-> (!evt_one.valid && !evt_two.valid))
        else $error("event from a sample inside the update interval");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic                            cfg_addr  = 1'b0;
    logic [tbphc_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // [31:0] now_ms, [32] button_one_level, [33] button_two_level, [39:34] zero
    logic [tbphc_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // [1:0] command, [7:2] zero
    logic [tbphc_pkg::M_TDATA_W-1:0] m_tdata;

    two_button_press_hold_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Classifier shadow: register copies and per-button state.
    // Index 0 is button one, index 1 is button two.
    // ------------------------------------------------------------------
    logic [tbphc_pkg::CFG_W-1:0]   upd_interval = tbphc_pkg::UPDATE_INTERVAL_RST;
    logic [tbphc_pkg::CFG_W-1:0]   long_press   = tbphc_pkg::LONG_PRESS_MS_RST;
    logic [tbphc_pkg::TIME_W-1:0]  last_eval_ms = '0;
    logic                          btn_prev   [2] = '{1'b0, 1'b0};
    logic [tbphc_pkg::TIMER_W-1:0] btn_timer  [2] = '{16'd0, 16'd0};
    logic                          btn_locked [2] = '{1'b0, 1'b0};

    tbphc_pkg::cmd_t expected_cmds[$];   // commands still owed by the DUT, oldest first
    int   fail_count = 0;
    bit   steady     = 1'b0;  // no idling on either side while set
    int   stall_left = 0;
    int unsigned stall_roll;

    // One button's evaluation on a sample that passed the interval gate.
    function automatic tbphc_pkg::btn_event_t eval_button(
        input logic b, input logic level, input logic [tbphc_pkg::TIME_W-1:0] elapsed);
        tbphc_pkg::btn_event_t         ev;
        logic [tbphc_pkg::TIMER_W:0]   sum;
        ev = '0;
        if (!btn_locked[b] && btn_prev[b] && level) begin
            // held on two evaluated samples: accumulate, saturating at 16 bits
            sum = {1'b0, btn_timer[b]} +
                  ((elapsed > 32'h0000_FFFF) ? 17'h0_FFFF : {1'b0, elapsed[15:0]});
            btn_timer[b] = sum[tbphc_pkg::TIMER_W] ? 16'hFFFF
                                                    : sum[tbphc_pkg::TIMER_W-1:0];
            if (btn_timer[b] >= long_press) begin
                btn_locked[b] = 1'b1;
                ev.valid      = 1'b1;
                ev.hold       = 1'b1;
            end
        end else if (btn_prev[b] && !level) begin
            // release: a press only if no hold was already reported
            if (!btn_locked[b]) begin
                ev.valid = 1'b1;
                ev.hold  = 1'b0;
            end
            btn_locked[b] = 1'b0;
            btn_timer[b]  = '0;
        end
        btn_prev[b] = level;
        return ev;
    endfunction

    // Works out the command (if any) caused by one accepted sample beat.
    function automatic void predict_command(input logic [tbphc_pkg::TIME_W-1:0] now,
                                            input logic b1, input logic b2);
        logic [tbphc_pkg::TIME_W-1:0] elapsed;
        tbphc_pkg::btn_event_t        ev1;
        tbphc_pkg::btn_event_t        ev2;
        if (now < last_eval_ms)
            last_eval_ms = now;      // clock went backwards
        elapsed = now - last_eval_ms;
        if (elapsed < {16'd0, upd_interval})
            return;                  // too early: sample ignored, no state change
        ev1 = eval_button(1'b0, b1, elapsed);
        ev2 = eval_button(1'b1, b2, elapsed);
        last_eval_ms = now;
        // button two wins when both fire on the same sample
        if (ev2.valid)
            expected_cmds.push_back(ev2.hold ? tbphc_pkg::CMD_TWO_HOLD
                                             : tbphc_pkg::CMD_TWO_PRESS);
        else if (ev1.valid)
            expected_cmds.push_back(ev1.hold ? tbphc_pkg::CMD_ONE_HOLD
                                             : tbphc_pkg::CMD_ONE_PRESS);
    endfunction

    // Gap after a beat: mostly none, some short, a few long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // Command sink: random back-pressure on m_tready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (steady) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 20)
                stall_left = $urandom_range(1, 3);
            else if (stall_roll < 23)
                stall_left = $urandom_range(10, 40);
            m_tready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Command checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : cmd_check
        tbphc_pkg::cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t: command beat %0d with none expected", $time, m_tdata[1:0]);
                fail_count++;
            end else begin
                want = expected_cmds.pop_front();
                if (m_tdata[1:0] !== want) begin
                    $display("%0t: command mismatch, expected %0d (%s), actual %0d",
                             $time, want, want.name(), m_tdata[1:0]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks. All of them start and end just after a rising edge.
    // ------------------------------------------------------------------

    // Drives one sample beat, waits for the handshake, then maybe idles.
    // tvalid stays high when the next beat follows at once.
    task automatic send_sample(input logic [tbphc_pkg::TIME_W-1:0] now,
                               input logic b1, input logic b2);
        int gap;
        s_tdata  <= {6'd0, b2, b1, now};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(now, b1, b2);
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender pauses until every owed command has come out, and then waits on
    // for an ignored sample that may still sit in the pipeline.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(input tbphc_pkg::cfg_reg_t idx,
                             input logic [tbphc_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == tbphc_pkg::REG_UPDATE_INTERVAL)
            upd_interval = val;
        else
            long_press = val;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (4 ms gate, 750 ms hold): gating, holds, presses,
    // lock suppressing the press, button two winning a tie.
    task automatic test_press_and_hold();
        send_sample(32'd0,    1'b0, 1'b0);   // elapsed 0: gated
        send_sample(32'd3,    1'b1, 1'b0);   // under interval: gated
        send_sample(32'd4,    1'b1, 1'b1);   // both rise
        send_sample(32'd104,  1'b1, 1'b1);   // both accumulate 100
        send_sample(32'd105,  1'b1, 1'b1);   // gated
        send_sample(32'd1000, 1'b1, 1'b1);   // both hit hold, two wins
        send_sample(32'd2000, 1'b1, 1'b1);   // locked and held: quiet
        send_sample(32'd2010, 1'b0, 1'b1);   // one released while locked
        send_sample(32'd2020, 1'b1, 1'b0);   // two released while locked
        send_sample(32'd2030, 1'b0, 1'b0);   // one short press
        send_sample(32'd2040, 1'b0, 1'b1);
        send_sample(32'd2050, 1'b0, 1'b0);   // two short press
    endtask

    // Time running backwards, timer saturation, the top of the time range.
    task automatic test_clock_backwards();
        send_sample(32'd100,        1'b0, 1'b0);  // backwards: elapsed 0, gated
        send_sample(32'd200,        1'b1, 1'b0);
        send_sample(32'h8000_0000,  1'b1, 1'b0);  // huge elapsed saturates -> hold
        send_sample(32'hFFFF_FFFF,  1'b0, 1'b1);
        send_sample(32'd5,          1'b0, 1'b1);  // wrapped: backwards again
    endtask

    // Zero gate: backwards samples still evaluate. Thresholds of one and zero.
    task automatic test_zero_interval();
        drain_results();
        write_reg(tbphc_pkg::REG_UPDATE_INTERVAL, 16'd0);
        write_reg(tbphc_pkg::REG_LONG_PRESS_MS,   16'd1);
        send_sample(32'd5000, 1'b1, 1'b0);
        send_sample(32'd100,  1'b1, 1'b0);   // backwards, zero elapsed, no hold
        send_sample(32'd101,  1'b1, 1'b0);   // 1 ms reaches threshold
        drain_results();
        write_reg(tbphc_pkg::REG_LONG_PRESS_MS, 16'd0);
        send_sample(32'd102,  1'b1, 1'b1);
        send_sample(32'd102,  1'b1, 1'b1);   // held twice, zero elapsed -> hold
    endtask

    // Random button activity under one register setting. Buttons follow a
    // toggling process so that holds and presses come often; some beats are
    // early, backwards, or jump anywhere in the 32-bit range.
    task automatic test_random_traffic(input logic [tbphc_pkg::CFG_W-1:0] ui,
                                       input logic [tbphc_pkg::CFG_W-1:0] lp,
                                       input int n_items, input bit no_idle);
        logic [tbphc_pkg::TIME_W-1:0] t;
        logic                         lv1;
        logic                         lv2;
        int unsigned                  flip_div;
        int unsigned                  r;
        drain_results();
        write_reg(tbphc_pkg::REG_UPDATE_INTERVAL, ui);
        write_reg(tbphc_pkg::REG_LONG_PRESS_MS,   lp);
        steady   = no_idle;
        t        = $urandom;
        if ($urandom_range(0, 1) == 1)
            t = 32'hFFFF_FFFF - $urandom_range(0, 200000);   // wrap soon
        lv1      = 1'b0;
        lv2      = 1'b0;
        flip_div = 6;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                flip_div = $urandom_range(2, 15);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // early sample with noise levels
                t = t + $urandom_range(0, 32'(upd_interval));
                send_sample(t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if (r < 14)
                    t = t - $urandom_range(1, 5000);
                else if (r < 17)
                    t = $urandom;
                else
                    t = t + 32'(upd_interval) +
                        $urandom_range(0, 32'(long_press) / 4 + 2);
                if ($urandom_range(0, flip_div - 1) == 0)
                    lv1 = ~lv1;
                if ($urandom_range(0, flip_div - 1) == 0)
                    lv2 = ~lv2;
                send_sample(t, lv1, lv2);
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_press_and_hold();
        test_clock_backwards();
        test_zero_interval();

        test_random_traffic(16'd4,     16'd750,   200, 1'b0);
        test_random_traffic(16'd0,     16'd1,     200, 1'b0);
        test_random_traffic(16'd65535, 16'd65535, 200, 1'b1);
        test_random_traffic(16'd0,     16'd65535, 150, 1'b0);
        test_random_traffic(16'd65535, 16'd1,     150, 1'b0);
        test_random_traffic(16'd1,     16'd10,    200, 1'b0);
        test_random_traffic(16'd20,    16'd300,   200, 1'b1);
        for (int k = 0; k < 3; k++)
            test_random_traffic(16'($urandom_range(0, 64)), 16'($urandom_range(1, 2000)),
                                200, 1'b0);

        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~2 ms)
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
